FILE: src/vdoa_pkg.sv
// Shared types and codes for the voxel delta overlay apply block.
`timescale 1ns / 1ps
`default_nettype none

package vdoa_pkg;

   // Item operation codes; codes above OP_READ behave like a read
   typedef enum logic [2:0] {
      OP_LOAD    = 3'd0,
      OP_ADD     = 3'd1,
      OP_REMOVE  = 3'd2,
      OP_REPLACE = 3'd3,
      OP_READ    = 3'd4
   } vdoa_op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_OOB  = 2'd1,
      ST_SKIP = 2'd2
   } vdoa_status_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_SIZE_X = 2'd0,
      CSR_SIZE_Y = 2'd1,
      CSR_SIZE_Z = 2'd2
   } vdoa_csr_type;

   // Back end sequencer states
   typedef enum logic {
      B_IDLE  = 1'b0,
      B_APPLY = 1'b1
   } vdoa_bstate_type;

   localparam int unsigned COORD_W  = 16;
   localparam int unsigned LABEL_W  = 8;
   localparam int unsigned SIZE_W   = 7;
   localparam int unsigned CELL_W   = LABEL_W + 1;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   // Classified item as it travels from front to back (address kept apart)
   typedef struct packed {
      vdoa_op_type        op;
      logic [LABEL_W-1:0] label;
      logic               occ;
      logic               authored;
      logic               oob;
   } vdoa_cmd_type;

endpackage

`default_nettype wire

FILE: src/vdoa_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module vdoa_ram #(
   parameter int unsigned WIDTH = 9,
   parameter int unsigned DEPTH = 262144
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     we,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write, and read the old contents
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: src/vdoa_fifo.sv
// Short register queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module vdoa_fifo #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] rdata,
   output      logic             full,
   output      logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

FILE: src/vdoa_front.sv
// Front end: grid extent registers, bounds check and address forming.
`timescale 1ns / 1ps
`default_nettype none

module vdoa_front
   import vdoa_pkg::*;
#(
   parameter int unsigned AXIS_BITS = 6
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [1:0]             csr_index,
   input  wire logic [SIZE_W-1:0]      csr_data,
   input  wire logic [2:0]             req_operation,
   input  wire logic [COORD_W-1:0]     req_coord_x,
   input  wire logic [COORD_W-1:0]     req_coord_y,
   input  wire logic [COORD_W-1:0]     req_coord_z,
   input  wire logic [LABEL_W-1:0]     req_label_in,
   input  wire logic                   req_occupied_in,
   input  wire logic                   req_authored,
   output      vdoa_cmd_type           cmd,
   output      logic [3*AXIS_BITS-1:0] cmd_addr
);

   localparam logic [COORD_W-1:0] AXIS_SPAN = COORD_W'(2 ** AXIS_BITS);

   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic              in_x, in_y, in_z;

   // Coordinate must be non-negative and below the clamped extent
   function automatic logic in_axis(input logic [COORD_W-1:0] c,
                                    input logic [SIZE_W-1:0]  ext);
      logic [COORD_W-1:0] lim;
      lim = {{(COORD_W - SIZE_W){1'b0}}, ext};
      if (lim > AXIS_SPAN) begin
         lim = AXIS_SPAN;
      end
      return !c[COORD_W-1] && (c < lim);
   endfunction

   // Hold the grid extents
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SIZE_X: size_x_ff <= csr_data;
            CSR_SIZE_Y: size_y_ff <= csr_data;
            CSR_SIZE_Z: size_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Classify the incoming item
   assign in_x = in_axis(req_coord_x, size_x_ff);
   assign in_y = in_axis(req_coord_y, size_y_ff);
   assign in_z = in_axis(req_coord_z, size_z_ff);

   always_comb begin
      cmd.op       = vdoa_op_type'(req_operation);
      cmd.label    = req_label_in;
      cmd.occ      = req_occupied_in;
      cmd.authored = req_authored;
      cmd.oob      = !(in_x && in_y && in_z);
   end

   assign cmd_addr = {req_coord_z[AXIS_BITS-1:0], req_coord_y[AXIS_BITS-1:0],
                      req_coord_x[AXIS_BITS-1:0]};

endmodule

`default_nettype wire

FILE: src/vdoa_back.sv
// Back end: read-modify-write of one voxel per item and the result register.
`timescale 1ns / 1ps
`default_nettype none

module vdoa_back
   import vdoa_pkg::*;
#(
   parameter int unsigned ADDR_W = 18
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire vdoa_cmd_type        q_cmd,
   input  wire logic [ADDR_W-1:0]   q_addr,
   output      logic                q_pop,
   output      logic [ADDR_W-1:0]   ram_addr,
   output      logic                ram_we,
   output      logic [CELL_W-1:0]   ram_wdata,
   input  wire logic [CELL_W-1:0]   ram_rdata,
   input  wire logic                rsp_pop,
   output      logic                rsp_valid,
   output      logic                rsp_occupied_out,
   output      logic [LABEL_W-1:0]  rsp_label_out,
   output      logic [1:0]          rsp_status
);

   vdoa_bstate_type    state_ff, state_in;
   vdoa_cmd_type       cmd_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_occ_ff;
   logic [LABEL_W-1:0] rsp_label_ff;
   vdoa_status_type    rsp_status_ff;
   logic               out_free, apply_fire, take;
   logic [CELL_W-1:0]  cell_new;
   vdoa_status_type    status_new;

   assign out_free = !rsp_valid_ff || rsp_pop;

   // Sequencer: issue the read, then apply once the result slot is free
   always_comb begin
      state_in   = state_ff;
      take       = 1'b0;
      apply_fire = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               take     = 1'b1;
               state_in = B_APPLY;
            end
         end
         B_APPLY: begin
            if (out_free) begin
               apply_fire = 1'b1;
               state_in   = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign q_pop    = take;
   assign ram_addr = (state_ff == B_IDLE) ? q_addr : addr_ff;

   // Modify the stored voxel
   always_comb begin
      cell_new   = ram_rdata;
      status_new = ST_DONE;
      case (cmd_ff.op)
         OP_LOAD:   cell_new = {cmd_ff.occ, cmd_ff.label};
         OP_ADD: begin
            if (ram_rdata[LABEL_W] && !cmd_ff.authored) begin
               status_new = ST_SKIP;
            end else begin
               cell_new = {1'b1, cmd_ff.label};
            end
         end
         OP_REMOVE: cell_new = {1'b0, ram_rdata[LABEL_W-1:0]};
         OP_REPLACE: begin
            if (ram_rdata[LABEL_W]) begin
               cell_new = {1'b1, cmd_ff.label};
            end
         end
         default:   cell_new = ram_rdata;
      endcase
      if (cmd_ff.oob) begin
         cell_new   = '0;
         status_new = ST_OOB;
      end
   end

   assign ram_we    = apply_fire && !cmd_ff.oob;
   assign ram_wdata = cell_new;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Latch the item and the result
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff  <= q_cmd;
         addr_ff <= q_addr;
      end
      if (apply_fire) begin
         rsp_occ_ff    <= cell_new[LABEL_W];
         rsp_label_ff  <= cell_new[LABEL_W-1:0];
         rsp_status_ff <= status_new;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_occupied_out = rsp_occ_ff;
   assign rsp_label_out    = rsp_label_ff;
   assign rsp_status       = rsp_status_ff;

   // A result appears only after an apply step
   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_APPLY))
      else $error("result appeared without an apply step");

   // Memory is written only while applying
   a_we_in_apply: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == B_APPLY) && out_free)
      else $error("voxel write outside apply step");

   // Out of bounds items never touch the store
   a_oob_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_APPLY) && cmd_ff.oob |-> !ram_we)
      else $error("out of bounds item wrote the store");

   // Out of bounds results report an empty voxel
   a_oob_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_OOB) |-> !rsp_occ_ff && (rsp_label_ff == '0))
      else $error("out of bounds result carries voxel data");

   // A waiting result holds while not popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pop |=> rsp_valid_ff && $stable(rsp_label_ff))
      else $error("waiting result changed");

endmodule

`default_nettype wire

FILE: src/voxel_delta_overlay_apply_core.sv
// Top level of the voxel delta overlay apply block.
//
//  Channel  Handshake            Moves
//  req      push / full          one item: operation, coordinates, label, flags
//  rsp      empty / pop          one result: occupancy, label, status
//  csr      valid / ready        one extent register write (ready is always high)
//
// The front end classifies one item per cycle while the queue is not full,
// into a QUEUE_DEPTH-deep queue. The back end handles one item at a time:
// a read of the single-port voxel RAM, then modify, write back and load of
// the result register once the result slot is free, before it takes the next.
// Reset is synchronous; the voxel RAM is not cleared and has no clearing pass.
// A held result stalls the back end only; the front keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none

module voxel_delta_overlay_apply_core
   import vdoa_pkg::*;
#(
   parameter int unsigned AXIS_BITS   = 6,
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output      logic               full,
   input  wire logic [2:0]         req_operation,
   input  wire logic [COORD_W-1:0] req_coord_x,
   input  wire logic [COORD_W-1:0] req_coord_y,
   input  wire logic [COORD_W-1:0] req_coord_z,
   input  wire logic [LABEL_W-1:0] req_label_in,
   input  wire logic               req_occupied_in,
   input  wire logic               req_authored,
   output      logic               empty,
   input  wire logic               pop,
   output      logic               rsp_occupied_out,
   output      logic [LABEL_W-1:0] rsp_label_out,
   output      logic [1:0]         rsp_status,
   input  wire logic               valid,
   output      logic               ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [SIZE_W-1:0]  csr_data
);

   localparam int unsigned ADDR_W  = 3 * AXIS_BITS;
   localparam int unsigned DEPTH   = 2 ** ADDR_W;
   localparam int unsigned CMD_W   = $bits(vdoa_cmd_type);
   localparam int unsigned QWIDTH  = CMD_W + ADDR_W;

   vdoa_cmd_type      f_cmd, q_cmd;
   logic [ADDR_W-1:0] f_addr, q_addr;
   logic [QWIDTH-1:0] q_rdata;
   logic              q_empty, q_pop;
   logic [ADDR_W-1:0] ram_addr;
   logic              ram_we;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;
   logic              rsp_valid;

   assign ready = 1'b1;

   // Classify and hold extents
   vdoa_front #(.AXIS_BITS(AXIS_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (valid && ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_operation   (req_operation),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_label_in    (req_label_in),
      .req_occupied_in (req_occupied_in),
      .req_authored    (req_authored),
      .cmd             (f_cmd),
      .cmd_addr        (f_addr)
   );

   // Decouple front and back
   vdoa_fifo #(.WIDTH(QWIDTH), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata ({f_addr, f_cmd}),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (full),
      .empty (q_empty)
   );

   assign q_cmd  = vdoa_cmd_type'(q_rdata[CMD_W-1:0]);
   assign q_addr = q_rdata[QWIDTH-1:CMD_W];

   // Apply items to the store
   vdoa_back #(.ADDR_W(ADDR_W)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_cmd            (q_cmd),
      .q_addr           (q_addr),
      .q_pop            (q_pop),
      .ram_addr         (ram_addr),
      .ram_we           (ram_we),
      .ram_wdata        (ram_wdata),
      .ram_rdata        (ram_rdata),
      .rsp_pop          (pop),
      .rsp_valid        (rsp_valid),
      .rsp_occupied_out (rsp_occupied_out),
      .rsp_label_out    (rsp_label_out),
      .rsp_status       (rsp_status)
   );

   assign empty = !rsp_valid;

   // Voxel store
   vdoa_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire
